@@ sv/ats_pkg.sv @@
// Package: request codes and sequencer states for the alias table sampler.
`timescale 1ns / 1ps
package ats_pkg;
    localparam logic [1:0] REQ_UPDATE = 2'd0;
    localparam logic [1:0] REQ_BUILD  = 2'd1;
    localparam logic [1:0] REQ_SAMPLE = 2'd2;

    typedef enum logic [17:0] {
        S_IDLE    = 18'b000000000000000001,
        S_URD     = 18'b000000000000000010,
        S_UWR     = 18'b000000000000000100,
        S_SRD     = 18'b000000000000001000,
        S_SCMP    = 18'b000000000000010000,
        S_TSUM    = 18'b000000000000100000,
        S_TSUMW   = 18'b000000000001000000,
        S_SCRD    = 18'b000000000010000000,
        S_SCDIV   = 18'b000000000100000000,
        S_SCWR    = 18'b000000001000000000,
        S_PAIR    = 18'b000000010000000000,
        S_PAIRW   = 18'b000000100000000000,
        S_LEFTL   = 18'b000001000000000000,
        S_LEFTS   = 18'b000010000000000000,
        S_NEXT    = 18'b000100000000000000,
        S_OUT     = 18'b001000000000000000,
        S_PAIRR   = 18'b010000000000000000,
        S_PAIRU   = 18'b100000000000000000
    } t_state;
endpackage

@@ sv/ats_ram.sv @@
// Generic single-port write, single read port RAM with registered read.
`timescale 1ns / 1ps
module ats_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ sv/ats_div.sv @@
// Restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module ats_div #(
    parameter int NW = 40,
    parameter int DW = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] r_q;
    logic [DW:0]   r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [DW:0]   w_sh;
    assign w_sh = {r_rem[DW-1:0], r_q[NW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_q    <= i_num;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (w_sh >= {1'b0, i_den}) begin
                    r_rem <= w_sh - {1'b0, i_den};
                    r_q   <= {r_q[NW-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_q   <= {r_q[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quot = r_q;
endmodule

@@ sv/alias_table_sampler.sv @@
// Top level: per-tile alias method sampler with count updates and table builds.
`timescale 1ns / 1ps
// Channel | Dir | Fields (low bit up)
// s_axis  | in  | tdata: tile_index[5:0] mode_index[9:6] amount[25:10] random_index[29:26]
//         |     |        random_fraction[45:30]; tuser: req_type
// m_axis  | out | tdata: chosen_mode[3:0] index_error[4]; tuser: result_kind
// cfg     | in  | num_modes, 5 bits
// Update and sample: accept, read, write or compare, then the result word. Build:
// per tile, sum the counts, scale each mode through the one shared bit-serial
// divider, then pair small and large modes and settle the leftovers.
// Reset clears the count and alias RAMs and sets every keep threshold to one in a
// pass over all NUM_TILES*MAX_MODES cells, no input taken meanwhile. Input stalls
// while a result waits on m_axis.
module alias_table_sampler #(
    parameter int NUM_TILES  = 64,
    parameter int MAX_MODES  = 16,
    parameter int COUNT_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // tile, mode, amount, random_index, random_fraction
    input  logic [1:0]  s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // chosen_mode, index_error
    output logic [1:0]  m_axis_tuser,  // result_kind
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata
);
    localparam int MB   = $clog2(MAX_MODES);
    localparam int TB   = (NUM_TILES > 1) ? $clog2(NUM_TILES) : 1;
    localparam int CELLS = NUM_TILES * MAX_MODES;
    localparam int AB   = $clog2(CELLS);
    localparam int NB   = $clog2(MAX_MODES + 1);
    localparam int SB   = COUNT_BITS + MB + 1;       // sum width
    localparam int KB   = FRAC_BITS + 1;             // threshold width
    localparam int WB   = FRAC_BITS + MB + 2;        // scaled work width
    localparam int QB   = COUNT_BITS + NB + FRAC_BITS;
    localparam logic [WB-1:0] ONE_W = WB'(1) << FRAC_BITS;
    localparam logic [KB-1:0] ONE_K = KB'(1) << FRAC_BITS;

    ats_pkg::t_state r_st;
    logic [1:0]  r_kind;
    logic [5:0]  r_tile_in;
    logic [3:0]  r_mode_in, r_ridx;
    logic [15:0] r_amt, r_frac;
    logic [4:0]  r_nm;
    logic [3:0]  r_chosen;
    logic        r_err;
    logic        r_clr;
    logic [AB:0] r_clr_a;
    logic [TB:0] r_tile;
    logic [NB-1:0] r_j;
    logic [SB-1:0] r_sum;
    logic [NB-1:0] r_sd, r_ld;
    logic [MB-1:0] r_sstk [MAX_MODES];
    logic [MB-1:0] r_lstk [MAX_MODES];
    logic [WB-1:0] r_work [MAX_MODES];
    logic [MB-1:0] r_s, r_l;
    logic        r_dstart;

    logic [NB-1:0] w_n;
    always_comb begin
        if (r_nm == 5'd0) w_n = NB'(1);
        else if (32'(r_nm) > MAX_MODES) w_n = NB'(MAX_MODES);
        else w_n = NB'(r_nm);
    end

    // RAM ports
    logic cnt_we, kp_we, al_we;
    logic [AB-1:0] cnt_wa, kp_wa, al_wa, ra;
    logic [COUNT_BITS-1:0] cnt_wd, cnt_rd;
    logic [KB-1:0] kp_wd, kp_rd;
    logic [MB-1:0] al_wd, al_rd;

    ats_ram #(.WIDTH(COUNT_BITS), .DEPTH(CELLS)) u_cnt (.i_clk, .i_we(cnt_we),
        .i_waddr(cnt_wa), .i_wdata(cnt_wd), .i_raddr(ra), .o_rdata(cnt_rd));
    ats_ram #(.WIDTH(KB), .DEPTH(CELLS)) u_keep (.i_clk, .i_we(kp_we),
        .i_waddr(kp_wa), .i_wdata(kp_wd), .i_raddr(ra), .o_rdata(kp_rd));
    ats_ram #(.WIDTH(MB), .DEPTH(CELLS)) u_alias (.i_clk, .i_we(al_we),
        .i_waddr(al_wa), .i_wdata(al_wd), .i_raddr(ra), .o_rdata(al_rd));

    logic          d_done;
    logic [QB-1:0] d_q;
    ats_div #(.NW(QB), .DW(SB)) u_div (.i_clk, .i_rst_n, .i_start(r_dstart),
        .i_num({cnt_rd, FRAC_BITS'(0)} * QB'(w_n)), .i_den(r_sum),
        .o_done(d_done), .o_quot(d_q));

    logic [AB-1:0] w_base;
    assign w_base = AB'(32'(r_tile[TB-1:0]) * MAX_MODES);

    // saturating add
    logic signed [COUNT_BITS+17:0] w_add;
    logic [COUNT_BITS-1:0] w_sat;
    always_comb begin
        w_add = $signed({18'd0, cnt_rd}) + (COUNT_BITS+18)'($signed(r_amt));
        if (w_add < 0) w_sat = '0;
        else if (w_add > $signed((COUNT_BITS+18)'({COUNT_BITS{1'b1}})))
            w_sat = {COUNT_BITS{1'b1}};
        else w_sat = w_add[COUNT_BITS-1:0];
    end

    logic [WB-1:0] w_comb;
    assign w_comb = r_work[r_l] + r_work[r_s] - ONE_W;
    logic [KB-1:0] w_u;
    assign w_u = (FRAC_BITS >= 16) ? (KB'(r_frac) << (FRAC_BITS - 16))
                                   : KB'(r_frac >> (16 - FRAC_BITS));

    always_comb begin
        cnt_we = 1'b0; kp_we = 1'b0; al_we = 1'b0;
        cnt_wa = '0; kp_wa = '0; al_wa = '0;
        cnt_wd = w_sat; kp_wd = ONE_K; al_wd = r_l;
        ra = '0;
        if (r_clr) begin
            cnt_we = 1'b1; kp_we = 1'b1; al_we = 1'b1;
            cnt_wa = r_clr_a[AB-1:0]; kp_wa = r_clr_a[AB-1:0]; al_wa = r_clr_a[AB-1:0];
            cnt_wd = '0; al_wd = '0;
        end else begin
            unique case (r_st)
                ats_pkg::S_URD:
                    ra = AB'(32'(r_tile_in) * MAX_MODES + 32'(r_mode_in));
                ats_pkg::S_UWR: begin
                    cnt_we = 1'b1;
                    cnt_wa = AB'(32'(r_tile_in) * MAX_MODES + 32'(r_mode_in));
                end
                ats_pkg::S_SRD:
                    ra = AB'(32'(r_tile_in) * MAX_MODES + 32'(r_ridx));
                ats_pkg::S_TSUM, ats_pkg::S_SCRD:
                    ra = w_base + AB'(r_j);
                ats_pkg::S_PAIRU: begin
                    kp_we = 1'b1; kp_wa = w_base + AB'(r_s);
                    kp_wd = KB'(r_work[r_s]);
                    al_we = 1'b1; al_wa = w_base + AB'(r_s);
                end
                ats_pkg::S_LEFTL: begin
                    kp_we = (r_ld != '0); kp_wa = w_base + AB'(r_lstk[MB'(r_ld - 1'b1)]);
                end
                ats_pkg::S_LEFTS: begin
                    kp_we = (r_sd != '0); kp_wa = w_base + AB'(r_sstk[MB'(r_sd - 1'b1)]);
                end
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !r_clr && (r_st == ats_pkg::S_IDLE);
    assign m_axis_tvalid = (r_st == ats_pkg::S_OUT);
    assign m_axis_tdata  = {3'd0, r_err, r_chosen};
    assign m_axis_tuser  = r_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ats_pkg::S_IDLE;
            r_nm     <= 5'd16;
            r_clr    <= 1'b1;
            r_clr_a  <= '0;
            r_dstart <= 1'b0;
            r_sd     <= '0;
            r_ld     <= '0;
        end else begin
            r_dstart <= 1'b0;
            if (i_cfg_we) r_nm <= i_cfg_wdata;
            if (r_clr) begin
                r_clr_a <= r_clr_a + 1'b1;
                if (r_clr_a == (AB+1)'(CELLS - 1)) r_clr <= 1'b0;
            end
            unique case (r_st)
                ats_pkg::S_IDLE: if (s_axis_tready && s_axis_tvalid) begin
                    r_kind    <= s_axis_tuser;
                    r_tile_in <= s_axis_tdata[5:0];
                    r_mode_in <= s_axis_tdata[9:6];
                    r_amt     <= s_axis_tdata[25:10];
                    r_ridx    <= s_axis_tdata[29:26];
                    r_frac    <= s_axis_tdata[45:30];
                    r_chosen  <= '0;
                    r_err     <= 1'b0;
                    r_tile    <= '0;
                    r_j       <= '0;
                    r_sum     <= '0;
                    case (s_axis_tuser)
                        ats_pkg::REQ_UPDATE:
                            r_st <= (32'(s_axis_tdata[5:0]) < NUM_TILES &&
                                     NB'(s_axis_tdata[9:6]) < w_n && 32'(s_axis_tdata[9:6]) < MAX_MODES)
                                    ? ats_pkg::S_URD : ats_pkg::S_OUT;
                        ats_pkg::REQ_BUILD:  r_st <= ats_pkg::S_TSUM;
                        ats_pkg::REQ_SAMPLE: begin
                            if (NB'(s_axis_tdata[29:26]) >= w_n) begin
                                r_err <= 1'b1; r_st <= ats_pkg::S_OUT;
                            end else if (32'(s_axis_tdata[5:0]) < NUM_TILES)
                                r_st <= ats_pkg::S_SRD;
                            else r_st <= ats_pkg::S_OUT;
                        end
                        default: r_st <= ats_pkg::S_OUT;
                    endcase
                end
                ats_pkg::S_URD: r_st <= ats_pkg::S_UWR;
                ats_pkg::S_UWR: r_st <= ats_pkg::S_OUT;
                ats_pkg::S_SRD: r_st <= ats_pkg::S_SCMP;
                ats_pkg::S_SCMP: begin
                    r_chosen <= (w_u < kp_rd) ? r_ridx : 4'(al_rd);
                    r_st <= ats_pkg::S_OUT;
                end
                // sum counts of one tile, one read per cycle
                ats_pkg::S_TSUM: begin
                    if (r_j != '0) r_sum <= r_sum + SB'(cnt_rd);
                    if (r_j == w_n) r_st <= ats_pkg::S_TSUMW;
                    else r_j <= r_j + 1'b1;
                end
                ats_pkg::S_TSUMW: begin
                    r_j <= '0; r_sd <= '0; r_ld <= '0;
                    r_st <= (r_sum == '0) ? ats_pkg::S_NEXT : ats_pkg::S_SCRD;
                end
                ats_pkg::S_SCRD: begin
                    r_dstart <= 1'b1; r_st <= ats_pkg::S_SCDIV;
                end
                ats_pkg::S_SCDIV: if (d_done) r_st <= ats_pkg::S_SCWR;
                ats_pkg::S_SCWR: begin
                    r_work[r_j[MB-1:0]] <= WB'(d_q);
                    if (WB'(d_q) < ONE_W) begin
                        r_sstk[r_sd[MB-1:0]] <= r_j[MB-1:0]; r_sd <= r_sd + 1'b1;
                    end else begin
                        r_lstk[r_ld[MB-1:0]] <= r_j[MB-1:0]; r_ld <= r_ld + 1'b1;
                    end
                    r_j <= r_j + 1'b1;
                    r_st <= (r_j + 1'b1 == w_n) ? ats_pkg::S_PAIR : ats_pkg::S_SCRD;
                end
                ats_pkg::S_PAIR: begin
                    if (r_sd != '0 && r_ld != '0) begin
                        r_s  <= r_sstk[MB'(r_sd - 1'b1)];
                        r_l  <= r_lstk[MB'(r_ld - 1'b1)];
                        r_sd <= r_sd - 1'b1;
                        r_st <= ats_pkg::S_PAIRU;
                    end else r_st <= ats_pkg::S_LEFTL;
                end
                ats_pkg::S_PAIRU: begin
                    r_work[r_l] <= w_comb;
                    r_st <= ats_pkg::S_PAIRW;
                end
                ats_pkg::S_PAIRW: begin
                    if (r_work[r_l] < ONE_W) begin
                        r_ld <= r_ld - 1'b1;
                        r_sstk[r_sd[MB-1:0]] <= r_l; r_sd <= r_sd + 1'b1;
                    end
                    r_st <= ats_pkg::S_PAIRR;
                end
                ats_pkg::S_PAIRR: r_st <= ats_pkg::S_PAIR;
                ats_pkg::S_LEFTL: begin
                    if (r_ld != '0) r_ld <= r_ld - 1'b1;
                    else r_st <= ats_pkg::S_LEFTS;
                end
                ats_pkg::S_LEFTS: begin
                    if (r_sd != '0) r_sd <= r_sd - 1'b1;
                    else r_st <= ats_pkg::S_NEXT;
                end
                ats_pkg::S_NEXT: begin
                    r_j <= '0; r_sum <= '0;
                    r_tile <= r_tile + 1'b1;
                    r_st <= (r_tile + 1'b1 == (TB+1)'(NUM_TILES)) ? ats_pkg::S_OUT
                                                                  : ats_pkg::S_TSUM;
                end
                ats_pkg::S_OUT: if (m_axis_tready) r_st <= ats_pkg::S_IDLE;
                default: r_st <= ats_pkg::S_IDLE;
            endcase
        end
    end

    // hold result while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_nready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> !s_axis_tready) else $error("ready during clear");
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_err |-> r_chosen == '0) else $error("error with mode");
    a_stk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sd + r_ld <= w_n || r_st == ats_pkg::S_IDLE || r_st == ats_pkg::S_OUT)
        else $error("stack overflow");
endmodule
